[sv/rhc_pkg.sv]
// Shared types, constants and divider step function for the RGB to HSV converter.
// No dependencies; imported by rgb_to_hsv_converter.
`timescale 1ns / 1ps

package rhc_pkg;

	localparam int unsigned CH_W  = 8;
	localparam int unsigned HUE_W = 15;
	localparam int unsigned SAT_W = 17;
	localparam int unsigned NUM_W = 23;

	localparam int unsigned HUE_SCALE  = 64;
	localparam int unsigned SECTOR_DEG = 60;
	localparam int unsigned HUE_MAX    = 360 * HUE_SCALE - 1;
	localparam int unsigned SAT_MAX    = 65536;

	// Hue offsets already scaled by HUE_SCALE.
	localparam logic [HUE_W-1:0] OFFS_RED_POS = HUE_W'(0);
	localparam logic [HUE_W-1:0] OFFS_RED_NEG = HUE_W'(360 * HUE_SCALE);
	localparam logic [HUE_W-1:0] OFFS_GREEN   = HUE_W'(120 * HUE_SCALE);
	localparam logic [HUE_W-1:0] OFFS_BLUE    = HUE_W'(240 * HUE_SCALE);

	// Divider state carried through the long-division stages.
	typedef struct packed {
		logic [CH_W-1:0]  hrem;
		logic [HUE_W-1:0] hq;
		logic [HUE_W-1:0] hnum;
		logic [CH_W-1:0]  srem;
		logic [SAT_W-1:0] sq;
		logic [CH_W-1:0]  vmax;
		logic [CH_W-1:0]  delta;
	} div_t;

	// Runs the restoring division steps for quotient bits h_hi..h_lo of the hue
	// and s_hi..s_lo of the saturation. The bounds are constants at every call.
	function automatic div_t div_pass(div_t st, int h_hi, int h_lo, int s_hi, int s_lo);
		div_t           r;
		logic [CH_W:0]  trial;
		logic           nbit;
		r = st;
		for (int j = HUE_W - 1; j >= 0; j--) begin
			if (j <= h_hi && j >= h_lo) begin
				trial = {r.hrem, r.hnum[j]};
				if (trial >= {1'b0, r.delta}) begin
					r.hq[j] = 1'b1;
					r.hrem  = CH_W'(trial - {1'b0, r.delta});
				end else begin
					r.hrem  = trial[CH_W-1:0];
				end
			end
		end
		for (int j = SAT_W - 1; j >= 0; j--) begin
			if (j <= s_hi && j >= s_lo) begin
				// The saturation dividend is delta followed by sixteen zero bits.
				nbit  = (j == SAT_W - 1) ? r.delta[0] : 1'b0;
				trial = {r.srem, nbit};
				if (trial >= {1'b0, r.vmax}) begin
					r.sq[j] = 1'b1;
					r.srem  = CH_W'(trial - {1'b0, r.vmax});
				end else begin
					r.srem  = trial[CH_W-1:0];
				end
			end
		end
		return r;
	endfunction

endpackage

[sv/rgb_to_hsv_converter.sv]
// RGB to HSV converter: five-stage pipeline with two pipelined long dividers.
// Depends on rhc_pkg for widths, hue offsets and the divider step function.
//
//   channel   direction   handshake            payload
//   pixel     in          pix_valid/pix_stall  red, green, blue (8 bit each)
//   result    out         hsv_valid/hsv_stall  hue (15), saturation (17), brightness (8)
//
// One pixel per cycle is sustained while hsv_stall stays low; the depth of the
// pipeline is set by the fifteen and seventeen quotient bits of the two
// dividers, spread over three stages of five or six steps.
// Reset clears only the stage valid bits; data registers load without reset.
// A stall at the output holds the last stage, and earlier stages keep moving
// until they close up behind it, so bubbles are squeezed out and nothing is lost.
`timescale 1ns / 1ps

module rgb_to_hsv_converter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pix_valid,
	output logic                         pix_stall,
	input  logic [rhc_pkg::CH_W-1:0]     red,
	input  logic [rhc_pkg::CH_W-1:0]     green,
	input  logic [rhc_pkg::CH_W-1:0]     blue,
	output logic                         hsv_valid,
	input  logic                         hsv_stall,
	output logic [rhc_pkg::HUE_W-1:0]    hue,
	output logic [rhc_pkg::SAT_W-1:0]    saturation,
	output logic [rhc_pkg::CH_W-1:0]     brightness
);
	import rhc_pkg::*;

	// Stage valid bits and the ready chain. A stage moves when it is empty or
	// when the stage after it moves.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !v_s5 || !hsv_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign pix_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pix_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 1: largest and smallest component, delta, sector difference and
	// the sector offset. Ties go to red first, then green.
	logic [CH_W-1:0]        vmax_c, vmin_c;
	logic signed [CH_W:0]   diff_c;
	logic [HUE_W-1:0]       offs_c;

	always_comb begin
		vmax_c = (red > green) ? red : green;
		vmax_c = (vmax_c > blue) ? vmax_c : blue;
		vmin_c = (red < green) ? red : green;
		vmin_c = (vmin_c < blue) ? vmin_c : blue;
		priority if (red == vmax_c) begin
			diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
			offs_c = diff_c[CH_W] ? OFFS_RED_NEG : OFFS_RED_POS;
		end else if (green == vmax_c) begin
			diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
			offs_c = OFFS_GREEN;
		end else begin
			diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
			offs_c = OFFS_BLUE;
		end
	end

	logic [CH_W-1:0]       vmax_s1, delta_s1;
	logic signed [CH_W:0]  diff_s1;
	logic [HUE_W-1:0]      offs_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			vmax_s1  <= vmax_c;
			delta_s1 <= vmax_c - vmin_c;
			diff_s1  <= diff_c;
			offs_s1  <= offs_c;
		end
	end

	// Stage 2: hue dividend 3840*diff + offset*delta, which is never negative,
	// and the initial remainders of both dividers. Because every quotient fits
	// its field, the dividend bits above the quotient are already below the
	// divisor and seed the remainder directly.
	logic [NUM_W-1:0]          prod_off;
	logic signed [21:0]        prod_diff;
	logic signed [NUM_W+1:0]   num_wide;
	logic [NUM_W-1:0]          num_c;
	div_t                      init_c;

	always_comb begin
		prod_off  = NUM_W'(offs_s1) * NUM_W'(delta_s1);
		prod_diff = 22'(diff_s1) * 22'(SECTOR_DEG * HUE_SCALE);
		num_wide  = $signed({2'b00, prod_off}) + (NUM_W+2)'(prod_diff);
		num_c     = num_wide[NUM_W-1:0];
		init_c.hrem  = num_c[NUM_W-1:HUE_W];
		init_c.hq    = '0;
		init_c.hnum  = num_c[HUE_W-1:0];
		init_c.srem  = {1'b0, delta_s1[CH_W-1:1]};
		init_c.sq    = '0;
		init_c.vmax  = vmax_s1;
		init_c.delta = delta_s1;
	end

	div_t div_s2, div_s3, div_s4;

	always_ff @(posedge clk) begin
		if (rdy2) div_s2 <= init_c;
		if (rdy3) div_s3 <= div_pass(div_s2, 14, 10, 16, 11);
		if (rdy4) div_s4 <= div_pass(div_s3, 9, 5, 10, 5);
	end

	// Stage 5: last quotient bits, then grey and black pixels are forced to zero.
	div_t last_c;
	assign last_c = div_pass(div_s4, 4, 0, 4, 0);

	always_ff @(posedge clk) begin
		if (rdy5) begin
			hue        <= (last_c.delta == '0) ? '0 : last_c.hq;
			saturation <= (last_c.vmax == '0) ? '0 : last_c.sq;
			brightness <= last_c.vmax;
		end
	end

	assign hsv_valid = v_s5;

`ifndef NO_ASSERTIONS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hue <= HUE_W'(HUE_MAX))
		else $error("hue beyond 360 degrees");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> saturation <= SAT_W'(SAT_MAX))
		else $error("saturation above full scale");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && brightness == '0 |-> saturation == '0 && hue == '0)
		else $error("black pixel with nonzero hue or saturation");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && saturation == '0 |-> hue == '0)
		else $error("grey pixel with nonzero hue");

	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && div_s4.delta != '0 |-> div_s4.hrem < div_s4.delta)
		else $error("hue divider remainder not below divisor");
`endif

endmodule
